/* hw/rtl/gcfv_pkg.sv */
// Shared types, constants and decode functions for the GPU command FIFO
// with VRAM upload. Used by gcfv_res_fifo and gpu_command_fifo_vram_upload.
// No dependencies.
package gcfv_pkg;

	// VRAM geometry, in pixels (powers of two)
	localparam int VRAM_COLS   = 1024;
	localparam int VRAM_ROWS   = 512;
	localparam int COL_W       = $clog2(VRAM_COLS);
	localparam int ROW_W       = $clog2(VRAM_ROWS);
	localparam int COLP_W      = COL_W + 1;
	localparam int ROWP_W      = ROW_W + 1;
	localparam int ADDR_W      = 19;

	// Parameter buffer
	localparam int PARAM_DEPTH = 16;
	localparam int HELD_W      = $clog2(PARAM_DEPTH + 1);
	localparam int LEFT_W      = 4;

	// Result queue
	localparam int RES_DEPTH   = 4;
	localparam int RPTR_W      = $clog2(RES_DEPTH);
	localparam int RCNT_W      = RPTR_W + 1;

	// Port select
	localparam logic PORT_DRAW = 1'b0;
	localparam logic PORT_CTRL = 1'b1;

	// Control port commands
	localparam logic [7:0] CTRL_DMA_DIR = 8'h04;

	// Drawing port commands
	localparam logic [7:0] CMD_NOP            = 8'h00;
	localparam logic [7:0] CMD_CLEAR_CACHE    = 8'h01;
	localparam logic [7:0] CMD_FILL           = 8'h02;
	localparam logic [7:0] CMD_POLY3_MONO     = 8'h20;
	localparam logic [7:0] CMD_POLY3_MONO_T   = 8'h22;
	localparam logic [7:0] CMD_POLY4_MONO     = 8'h28;
	localparam logic [7:0] CMD_POLY4_MONO_T   = 8'h2A;
	localparam logic [7:0] CMD_POLY4_TEX      = 8'h2C;
	localparam logic [7:0] CMD_POLY3_SHADED   = 8'h30;
	localparam logic [7:0] CMD_POLY3_SHADED_T = 8'h32;
	localparam logic [7:0] CMD_POLY4_SHADED   = 8'h38;
	localparam logic [7:0] CMD_POLY4_SHADED_T = 8'h3A;
	localparam logic [7:0] CMD_LINE_MONO      = 8'h40;
	localparam logic [7:0] CMD_DOT            = 8'h68;
	localparam logic [7:0] CMD_CPU_TO_VRAM    = 8'hA0;
	localparam logic [7:0] CMD_VRAM_TO_CPU    = 8'hC0;
	localparam logic [7:0] CMD_DRAW_MODE      = 8'hE1;
	localparam logic [7:0] CMD_TEX_WINDOW     = 8'hE2;
	localparam logic [7:0] CMD_AREA_TL        = 8'hE3;
	localparam logic [7:0] CMD_AREA_BR        = 8'hE4;
	localparam logic [7:0] CMD_DRAW_OFFSET    = 8'hE5;
	localparam logic [7:0] CMD_MASK           = 8'hE6;

	typedef enum logic [1:0] {
		EV_ACCEPT  = 2'd0,
		EV_PIXEL   = 2'd1,
		EV_DONE    = 2'd2,
		EV_UNKNOWN = 2'd3
	} event_t;

	typedef struct packed {
		event_t              kind;
		logic [ADDR_W-1:0]   addr;
		logic [15:0]         pixel;
		logic [7:0]          code;
		logic [3:0]          count;
		logic [4:0]          status;
		logic [1:0]          dma;
		logic                last;
	} result_t;

	// Parameter words that follow a command word; zero for single-word commands
	function automatic logic [LEFT_W-1:0] param_words(input logic [7:0] op);
		logic [LEFT_W-1:0] n;
		unique case (op) inside
			CMD_FILL:                              n = LEFT_W'(2);
			CMD_POLY3_MONO, CMD_POLY3_MONO_T:      n = LEFT_W'(3);
			CMD_POLY4_MONO, CMD_POLY4_MONO_T:      n = LEFT_W'(4);
			CMD_POLY4_TEX:                         n = LEFT_W'(8);
			CMD_POLY3_SHADED, CMD_POLY3_SHADED_T:  n = LEFT_W'(5);
			CMD_POLY4_SHADED, CMD_POLY4_SHADED_T:  n = LEFT_W'(7);
			CMD_LINE_MONO:                         n = LEFT_W'(2);
			CMD_DOT:                               n = LEFT_W'(1);
			CMD_CPU_TO_VRAM:                       n = LEFT_W'(2);
			default:                               n = '0;
		endcase
		return n;
	endfunction

	function automatic logic plain_known(input logic [7:0] op);
		logic k;
		unique case (op) inside
			CMD_NOP, CMD_CLEAR_CACHE, CMD_VRAM_TO_CPU,
			CMD_DRAW_MODE, CMD_TEX_WINDOW, CMD_AREA_TL,
			CMD_AREA_BR, CMD_DRAW_OFFSET, CMD_MASK:  k = 1'b1;
			default:                                 k = 1'b0;
		endcase
		return k;
	endfunction

endpackage

/* hw/rtl/gcfv_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle.
// Depends on gcfv_pkg (result_t, RES_DEPTH).
module gcfv_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  gcfv_pkg::result_t push_a,
	input  gcfv_pkg::result_t push_b,
	input  logic              pop,
	output gcfv_pkg::result_t head,
	output logic              not_empty,
	output logic              room2
);

	gcfv_pkg::result_t               mem_q [gcfv_pkg::RES_DEPTH];
	logic [gcfv_pkg::RPTR_W-1:0]     rd_ptr_q;
	logic [gcfv_pkg::RPTR_W-1:0]     wr_ptr_q;
	logic [gcfv_pkg::RCNT_W-1:0]     count_q;
	logic [gcfv_pkg::RCNT_W-1:0]     count_after_pop;

	assign count_after_pop = count_q - gcfv_pkg::RCNT_W'(pop);
	assign room2     = count_after_pop <= gcfv_pkg::RCNT_W'(gcfv_pkg::RES_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + gcfv_pkg::RPTR_W'(1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + gcfv_pkg::RPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gcfv_pkg::RPTR_W'(1);
			end
			count_q <= count_after_pop + gcfv_pkg::RCNT_W'(push_n);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gcfv_pkg::RCNT_W'(gcfv_pkg::RES_DEPTH))
		else $error("result queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> ((gcfv_pkg::RCNT_W + 1)'(count_after_pop)
			+ (gcfv_pkg::RCNT_W + 1)'(push_n)
			<= (gcfv_pkg::RCNT_W + 1)'(gcfv_pkg::RES_DEPTH)))
		else $error("result queue overflow");

	a_first_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && push_n != 2'd0) |=> head == $past(push_a))
		else $error("result queue head does not match first push");

endmodule

/* hw/rtl/gpu_command_fifo_vram_upload.sv */
// GPU command FIFO with CPU-to-VRAM upload: top level.
// Depends on gcfv_pkg and gcfv_res_fifo.
//
// One word is taken per request, on the drawing port (opcode 0) or the control
// port (opcode 1). A word waits in the input register, where the whole step is
// worked out, until there is room for two results, and its results enter a
// four-entry result queue that the output channel drains one per cycle while
// out_ready is high. Every word gives one result except a load-mode data word,
// which gives two pixel writes (low half first), or one if the rectangle ends
// on its low half. Words giving one result are taken back to back at one per
// cycle while there is room; in an upload the single result port sets the pace.
// Only the command code and parameter words 1 and 2 (origin and size of an
// upload) are kept, since nothing else of the parameter buffer reaches a result.
module gpu_command_fifo_vram_upload (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [31:0]                  command_word,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   event_kind,
	output logic [gcfv_pkg::ADDR_W-1:0]  vram_address,
	output logic [15:0]                  vram_pixel,
	output logic [7:0]                   command_code,
	output logic [3:0]                   param_count,
	output logic [4:0]                   status_bits,
	output logic [1:0]                   dma_dir,
	output logic                         last_result
);

	localparam int CW  = gcfv_pkg::COL_W;
	localparam int RW  = gcfv_pkg::ROW_W;
	localparam int CPW = gcfv_pkg::COLP_W;
	localparam int RPW = gcfv_pkg::ROWP_W;
	localparam int HW  = gcfv_pkg::HELD_W;
	localparam int LW  = gcfv_pkg::LEFT_W;
	localparam int AW  = gcfv_pkg::ADDR_W;

	// input stage
	logic        valid_s1;
	logic        port_s1;
	logic [31:0] word_s1;
	logic        adv_s1;
	logic [7:0]  op;

	// command and upload state
	logic [LW-1:0]  left_q, left_d;
	logic [HW-1:0]  held_q, held_d;
	logic           load_q, load_d;
	logic [CW-1:0]  col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic [3:0]     page_x_q, page_x_d;
	logic           page_y_q, page_y_d;
	logic [1:0]     dma_q, dma_d;
	logic [7:0]     code_q, code_d;
	logic [CW-1:0]  x0_q, x0_d;
	logic [RW-1:0]  y0_q, y0_d;
	logic [CPW-1:0] wd_q, wd_d;
	logic [RPW-1:0] ht_q, ht_d;

	// rectangle walk for the two pixels of a data word
	logic [CPW-1:0] col1, col2;
	logic [RPW-1:0] row1, row2;
	logic           wrap_a, wrap_b, end_a, end_b;
	logic [CW-1:0]  col_b, col_n;
	logic [RW-1:0]  row_b, row_n;
	logic [AW-1:0]  addr_a, addr_b;
	logic [CW-1:0]  wd_m1;
	logic [RW-1:0]  ht_m1;

	// results
	gcfv_pkg::result_t res_a, res_b, head;
	logic [1:0]        n_res;
	logic [1:0]        push_n;
	logic              room2;
	logic              not_empty;
	logic              pop;

	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] c,
		input logic [RW-1:0] r, input logic [CW-1:0] x0, input logic [RW-1:0] y0);
		logic [CW-1:0] cx;
		logic [RW-1:0] ry;
		cx = c + x0;
		ry = r + y0;
		return AW'(ry) * AW'(gcfv_pkg::VRAM_COLS) + AW'(cx);
	endfunction

	assign adv_s1   = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;
	assign op       = word_s1[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			port_s1 <= opcode;
			word_s1 <= command_word;
		end
	end

	// first pixel at (col_q,row_q), second at (col_b,row_b)
	assign col1   = CPW'(col_q) + CPW'(1);
	assign row1   = RPW'(row_q) + RPW'(1);
	assign wrap_a = col1 >= wd_q;
	assign end_a  = wrap_a && (row1 >= ht_q);
	assign col_b  = wrap_a ? '0 : col1[CW-1:0];
	assign row_b  = wrap_a ? row1[RW-1:0] : row_q;
	assign col2   = CPW'(col_b) + CPW'(1);
	assign row2   = RPW'(row_b) + RPW'(1);
	assign wrap_b = col2 >= wd_q;
	assign end_b  = wrap_b && (row2 >= ht_q);
	assign col_n  = wrap_b ? '0 : col2[CW-1:0];
	assign row_n  = wrap_b ? row2[RW-1:0] : row_b;
	assign addr_a = pix_addr(col_q, row_q, x0_q, y0_q);
	assign addr_b = pix_addr(col_b, row_b, x0_q, y0_q);

	// zero size means the full VRAM extent
	assign wd_m1 = CW'(word_s1[15:0] - 16'd1);
	assign ht_m1 = RW'(word_s1[31:16] - 16'd1);

	always_comb begin
		left_d   = left_q;
		held_d   = held_q;
		load_d   = load_q;
		col_d    = col_q;
		row_d    = row_q;
		page_x_d = page_x_q;
		page_y_d = page_y_q;
		dma_d    = dma_q;
		code_d   = code_q;
		x0_d     = x0_q;
		y0_d     = y0_q;
		wd_d     = wd_q;
		ht_d     = ht_q;
		res_a    = '0;
		res_b    = '0;
		res_a.kind = gcfv_pkg::EV_ACCEPT;
		res_b.kind = gcfv_pkg::EV_PIXEL;
		n_res    = 2'd1;

		if (port_s1 == gcfv_pkg::PORT_CTRL) begin
			if (op == gcfv_pkg::CTRL_DMA_DIR) begin
				dma_d = word_s1[1:0];
			end
		end else if (load_q) begin
			res_a.kind  = gcfv_pkg::EV_PIXEL;
			res_a.addr  = addr_a;
			res_a.pixel = word_s1[15:0];
			if (end_a) begin
				// odd pixel count: drop the high half
				load_d = 1'b0;
			end else begin
				n_res       = 2'd2;
				res_b.addr  = addr_b;
				res_b.pixel = word_s1[31:16];
				col_d       = col_n;
				row_d       = row_n;
				if (end_b) begin
					load_d = 1'b0;
				end
			end
		end else if (left_q == '0) begin
			if (gcfv_pkg::param_words(op) != '0) begin
				held_d = HW'(1);
				left_d = gcfv_pkg::param_words(op);
				code_d = op;
			end else if (gcfv_pkg::plain_known(op)) begin
				if (op == gcfv_pkg::CMD_DRAW_MODE) begin
					page_x_d = word_s1[3:0];
					page_y_d = word_s1[4];
				end
			end else begin
				res_a.kind = gcfv_pkg::EV_UNKNOWN;
				res_a.code = op;
			end
		end else begin
			left_d = left_q - LW'(1);
			if (held_q < HW'(gcfv_pkg::PARAM_DEPTH)) begin
				held_d = held_q + HW'(1);
				if (held_q == HW'(1)) begin
					x0_d = CW'(word_s1[15:0]);
					y0_d = RW'(word_s1[31:16]);
				end
				if (held_q == HW'(2)) begin
					wd_d = CPW'(wd_m1) + CPW'(1);
					ht_d = RPW'(ht_m1) + RPW'(1);
				end
			end
			if (left_q == LW'(1)) begin
				res_a.kind  = gcfv_pkg::EV_DONE;
				res_a.code  = code_q;
				res_a.count = held_d[3:0];
				if (code_q == gcfv_pkg::CMD_CPU_TO_VRAM) begin
					load_d = 1'b1;
					col_d  = '0;
					row_d  = '0;
				end
			end
		end

		res_a.status = 5'(page_x_d) | (5'(page_y_d) << 3);
		res_b.status = res_a.status;
		res_a.dma    = dma_d;
		res_b.dma    = dma_d;
		res_a.last   = n_res == 2'd1;
		res_b.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			held_q   <= '0;
			load_q   <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			page_x_q <= '0;
			page_y_q <= 1'b0;
			dma_q    <= '0;
		end else if (adv_s1) begin
			left_q   <= left_d;
			held_q   <= held_d;
			load_q   <= load_d;
			col_q    <= col_d;
			row_q    <= row_d;
			page_x_q <= page_x_d;
			page_y_q <= page_y_d;
			dma_q    <= dma_d;
		end
	end

	// parameter buffer contents: valid only once written
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			code_q <= code_d;
			x0_q   <= x0_d;
			y0_q   <= y0_d;
			wd_q   <= wd_d;
			ht_q   <= ht_d;
		end
	end

	assign push_n = adv_s1 ? n_res : 2'd0;
	assign pop    = not_empty && out_ready;

	gcfv_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign out_valid    = not_empty;
	assign event_kind   = head.kind;
	assign vram_address = head.addr;
	assign vram_pixel   = head.pixel;
	assign command_code = head.code;
	assign param_count  = head.count;
	assign status_bits  = head.status;
	assign dma_dir      = head.dma;
	assign last_result  = head.last;

	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> left_q == '0)
		else $error("upload active while gathering parameters");

	a_walk_inside: assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> (CPW'(col_q) < wd_q) && (RPW'(row_q) < ht_q))
		else $error("upload position outside the rectangle");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room2) |=> valid_s1 && $stable(word_s1) && $stable(port_s1))
		else $error("stalled input stage lost its word");

endmodule
